>>> sv/aqdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqdc_pkg: shared types and constants for the queue depth controller
// Payload structs, register indexes, window state and constant-factor values.
// ----------------------------------------------------------------------------
package aqdc_pkg;

    localparam int DEPTH_W   = 13;
    localparam int TARGET_W  = 31;
    localparam int LAT_W     = 32;
    localparam int BYTES_W   = 32;
    localparam int SUM_W     = 35;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    // reports per evaluation window
    localparam logic [COUNT_W-1:0] WINDOW_LEN = 5'd8;

    // floor(x/10) = (x*52429) >> 19 and floor(x/5) = (x*52429) >> 18, exact for 16-bit x
    localparam logic [15:0] RECIP_MUL = 16'd52429;

    // register reset values
    localparam logic [DEPTH_W-1:0]  INITIAL_DEPTH_RST = 13'd32;
    localparam logic [DEPTH_W-1:0]  MIN_DEPTH_RST     = 13'd1;
    localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST     = 13'd256;
    localparam logic [TARGET_W-1:0] TARGET_RST        = 31'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DEPTH = 2'd0,
        CFG_MIN_DEPTH     = 2'd1,
        CFG_MAX_DEPTH     = 2'd2,
        CFG_TARGET        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                      is_fsync;
        logic signed [BYTES_W-1:0] result_bytes;
        logic [LAT_W-1:0]          latency_us;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_limit;
        logic               window_closed;
    } out_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] current_depth;
        logic [SUM_W-1:0]   window_byte_sum;
        logic [COUNT_W-1:0] window_count;
        logic [LAT_W-1:0]   window_max_latency;
        logic [SUM_W-1:0]   previous_window_bytes;
    } win_state_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]  min_depth;
        logic [DEPTH_W-1:0]  max_depth;
        logic [TARGET_W-1:0] target_latency_us;
    } limits_t;

    typedef struct packed {
        win_state_t state;
        logic       counted;
        logic       closed;
    } eval_result_t;

endpackage

>>> sv/aqdc_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqdc_eval: per-report window update and depth adjustment
// Accumulates bytes and peak latency, and at window end rescales the depth.
// ----------------------------------------------------------------------------
module aqdc_eval
    import aqdc_pkg::*;
(
    input  in_item_t     item,
    input  win_state_t   state,
    input  limits_t      limits,
    output eval_result_t result
);

    logic                 counted;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sum_new;
    logic [LAT_W-1:0]     lat_new;
    logic [COUNT_W-1:0]   count_inc;
    logic                 closes;
    logic                 too_slow;
    logic                 fast_enough;
    logic [SUM_W+5:0]     bytes_x50;
    logic [SUM_W+5:0]     prev_x49;
    logic [15:0]          depth_x7;
    logic [15:0]          depth_x6;
    logic [31:0]          dec_prod;
    logic [31:0]          inc_prod;
    logic [DEPTH_W-1:0]   dec_depth;
    logic [DEPTH_W:0]     inc_depth;
    logic [DEPTH_W-1:0]   dec_sel;
    logic [DEPTH_W-1:0]   inc_sel;
    logic [SUM_W+5:0]     sum_ext;
    logic [SUM_W+5:0]     prev_ext;

    // only positive non-flush reports enter the window
    assign counted = !item.is_fsync && !item.result_bytes[BYTES_W-1]
                     && (item.result_bytes != '0);

    assign sum_wide  = {1'b0, state.window_byte_sum}
                       + (SUM_W+1)'(item.result_bytes[BYTES_W-2:0]);
    assign sum_new   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign lat_new   = (item.latency_us > state.window_max_latency)
                       ? item.latency_us : state.window_max_latency;
    assign count_inc = state.window_count + 1'b1;
    assign closes    = counted && (count_inc >= WINDOW_LEN);

    assign too_slow  = lat_new > {limits.target_latency_us, 1'b0};
    assign fast_enough = lat_new < {1'b0, limits.target_latency_us};

    // x*50 = x*32 + x*16 + x*2, x*49 = x*32 + x*16 + x
    assign sum_ext   = (SUM_W+6)'(sum_new);
    assign prev_ext  = (SUM_W+6)'(state.previous_window_bytes);
    assign bytes_x50 = (sum_ext << 5) + (sum_ext << 4) + (sum_ext << 1);
    assign prev_x49  = (prev_ext << 5) + (prev_ext << 4) + prev_ext;

    // decrease: floor(depth*7/10)
    assign depth_x7  = (16'(state.current_depth) << 3) - 16'(state.current_depth);
    assign dec_prod  = 32'(depth_x7) * 32'(RECIP_MUL);
    assign dec_depth = dec_prod[31:19];
    assign dec_sel   = (dec_depth < limits.min_depth) ? limits.min_depth : dec_depth;

    // increase: floor(depth*6/5) + 1
    assign depth_x6  = (16'(state.current_depth) << 2) + (16'(state.current_depth) << 1);
    assign inc_prod  = 32'(depth_x6) * 32'(RECIP_MUL);
    assign inc_depth = inc_prod[31:18] + 1'b1;
    assign inc_sel   = (inc_depth > {1'b0, limits.max_depth})
                       ? limits.max_depth : inc_depth[DEPTH_W-1:0];

    always_comb
    begin
        result.state   = state;
        result.counted = counted;
        result.closed  = closes;
        if (closes)
        begin
            if (too_slow)
            begin
                result.state.current_depth = dec_sel;
            end
            else if (fast_enough && (bytes_x50 >= prev_x49))
            begin
                result.state.current_depth = inc_sel;
            end
            result.state.previous_window_bytes = sum_new;
            result.state.window_byte_sum       = '0;
            result.state.window_count          = '0;
            result.state.window_max_latency    = '0;
        end
        else if (counted)
        begin
            result.state.window_byte_sum    = sum_new;
            result.state.window_max_latency = lat_new;
            result.state.window_count       = count_inc;
        end
    end

endmodule

>>> sv/adaptive_queue_depth_control.sv
`timescale 1ns / 1ps
// a result passes the input register, then the result register, before it is valid on the output
// throughput: one report per cycle while out_ready is high; window update and rescale are combinational
// while a result waits on the output the input register takes one more report, then stalls
// reset: asynchronous active low; registers return to depth 32, min 1, max 256, target 1000,
// and the window and previous-window byte count clear to zero
// ----------------------------------------------------------------------------
// adaptive_queue_depth_control: latency-driven queue depth limit
// Watches completion reports, gathers a window of them and scales the depth limit down
// when peak latency is high, up when it is low and bytes reach 98% of the previous window.
// ----------------------------------------------------------------------------
module adaptive_queue_depth_control
    import aqdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // completion reports
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    // depth results
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // input register stage
    logic         s1_valid_reg;
    logic         s1_valid_next;
    in_item_t     s1_item_reg;
    logic         s1_advance;

    // result register stage
    logic         res_valid_reg;
    logic         res_valid_next;
    out_item_t    res_item_reg;

    // window state and configuration
    win_state_t   state_reg;
    win_state_t   state_next;
    limits_t      limits_reg;
    limits_t      limits_next;
    logic [DEPTH_W-1:0] init_depth_reg;
    logic [DEPTH_W-1:0] init_depth_next;

    eval_result_t eval;

    // register writes are always taken; software writes only while idle
    assign cfg_ready = 1'b1;

    // the item in the input register moves on whenever the result slot is free or draining
    assign s1_advance = s1_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign out_valid  = res_valid_reg;
    assign out_data   = res_item_reg;

    aqdc_eval u_eval
    (
        .item   (s1_item_reg),
        .state  (state_reg),
        .limits (limits_reg),
        .result (eval)
    );

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        res_valid_next = s1_advance ? 1'b1 : (res_valid_reg && !out_ready);
    end

    // state moves on only when a report leaves the input register; an initial-depth write loads its depth
    always_comb
    begin
        state_next      = s1_advance ? eval.state : state_reg;
        limits_next     = limits_reg;
        init_depth_next = init_depth_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INITIAL_DEPTH:
                begin
                    init_depth_next          = cfg_data[DEPTH_W-1:0];
                    state_next.current_depth = cfg_data[DEPTH_W-1:0];
                end
                CFG_MIN_DEPTH:     limits_next.min_depth         = cfg_data[DEPTH_W-1:0];
                CFG_MAX_DEPTH:     limits_next.max_depth         = cfg_data[DEPTH_W-1:0];
                CFG_TARGET:        limits_next.target_latency_us = cfg_data[TARGET_W-1:0];
                default:           limits_next                   = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg                    <= 1'b0;
            res_valid_reg                   <= 1'b0;
            state_reg.current_depth         <= INITIAL_DEPTH_RST;
            state_reg.window_byte_sum       <= '0;
            state_reg.window_count          <= '0;
            state_reg.window_max_latency    <= '0;
            state_reg.previous_window_bytes <= '0;
            limits_reg.min_depth            <= MIN_DEPTH_RST;
            limits_reg.max_depth            <= MAX_DEPTH_RST;
            limits_reg.target_latency_us    <= TARGET_RST;
            init_depth_reg                  <= INITIAL_DEPTH_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
            limits_reg    <= limits_next;
            init_depth_reg <= init_depth_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_advance)
        begin
            res_item_reg.depth_limit   <= eval.state.current_depth;
            res_item_reg.window_closed <= eval.closed;
        end
    end

    // the window never holds a full set of reports between transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.window_count < WINDOW_LEN)
        else $error("window count reached window length without closing");

    // an ignored report leaves the window untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !eval.counted
        |=> $stable(state_reg.window_count) && $stable(state_reg.window_byte_sum)
            && $stable(state_reg.window_max_latency))
        else $error("ignored report changed window state");

    // a closed window leaves an empty window behind
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && eval.closed
        |=> (state_reg.window_count == '0) && (state_reg.window_byte_sum == '0))
        else $error("window not cleared after evaluation");

    // a held report blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |-> !in_ready)
        else $error("input taken while input register is held");

endmodule

>>> bench/tb_adaptive_queue_depth_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_queue_depth_control: self-checking bench for the depth controller
// A directed table covers ignored reports, field extremes and register masking.
// Random windows then run under several register settings with random idling
// on both channels. Every result is compared with its typed table value or a software depth tracker.
// ----------------------------------------------------------------------------
module tb_adaptive_queue_depth_control;

    import aqdc_pkg::*;

    localparam int MAX_WAIT          = 17;
    localparam int HOLD_CYCLES       = 64;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 600000;
    localparam int PHASES            = 10;
    localparam int WINDOWS_PER_PHASE = 13;
    localparam logic [63:0] SUM_CAP  = (64'd1 << SUM_W) - 64'd1;

    typedef enum logic {
        ROW_REPORT,
        ROW_WRITE
    } row_kind_t;

    // one line of the directed table: a report or a register write
    typedef struct packed {
        row_kind_t              kind;
        cfg_index_t             reg_idx;
        logic [CFG_DAT_W-1:0]   reg_val;
        in_item_t               report;
        logic                   typed;
        out_item_t              golden;
    } plan_row_t;

    // result typed into the table, or a flag saying the tracker decides
    typedef struct packed {
        logic      typed;
        out_item_t golden;
    } preset_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // tracker copy of the window state and limit registers
    win_state_t track = '0;
    limits_t    limits = '0;

    out_item_t  pending_depths[$];
    preset_t    preset_q[$];
    int         mismatches = 0;
    int         cycle_count = 0;

    // idling controls for the sender and the receiver; calm is shared by both
    logic       calm = 1'b0;
    logic       burst = 1'b0;
    logic       hold_req = 1'b0;

    adaptive_queue_depth_control u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // run limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // depth tracker: advances the window by one report and returns the result
    function automatic out_item_t predict_depth(input in_item_t r);
        logic [63:0] sum;
        logic [63:0] nd;
        logic [63:0] peak;
        logic [63:0] tgt;
        logic [63:0] prev;
        out_item_t   res;
        res.window_closed = 1'b0;
        // flushes and zero or negative results leave the window alone
        if (!r.is_fsync && !r.result_bytes[BYTES_W-1] && r.result_bytes != '0)
        begin
            sum = 64'(track.window_byte_sum);
            sum = sum + 64'(r.result_bytes[BYTES_W-1:0]);
            if (sum > SUM_CAP)
                sum = SUM_CAP;
            track.window_byte_sum = sum[SUM_W-1:0];
            if (r.latency_us > track.window_max_latency)
                track.window_max_latency = r.latency_us;
            track.window_count = track.window_count + 1'b1;
            if (track.window_count >= WINDOW_LEN)
            begin
                peak = 64'(track.window_max_latency);
                tgt  = 64'(limits.target_latency_us);
                prev = 64'(track.previous_window_bytes);
                nd   = 64'(track.current_depth);
                // with a short window the tail percentile is the window peak
                if (peak > 2 * tgt)
                begin
                    nd = nd * 7 / 10;
                    if (nd < 64'(limits.min_depth))
                        nd = 64'(limits.min_depth);
                    track.current_depth = nd[DEPTH_W-1:0];
                end
                else if (peak < tgt && sum * 50 >= prev * 49)
                begin
                    nd = nd * 6 / 5 + 1;
                    if (nd > 64'(limits.max_depth))
                        nd = 64'(limits.max_depth);
                    track.current_depth = nd[DEPTH_W-1:0];
                end
                track.previous_window_bytes = sum[SUM_W-1:0];
                track.window_byte_sum = '0;
                track.window_count = '0;
                track.window_max_latency = '0;
                res.window_closed = 1'b1;
            end
        end
        res.depth_limit = track.current_depth;
        return res;
    endfunction

    // scoreboard: all three channels sampled at the rising edge
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        out_item_t got;
        preset_t   tag;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_depths.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing pending: depth %0d",
                        out_data.depth_limit));
                else
                begin
                    want = pending_depths.pop_front();
                    if (out_data.depth_limit !== want.depth_limit)
                        report_mismatch($sformatf("depth_limit %0d, expected %0d",
                            out_data.depth_limit, want.depth_limit));
                    if (out_data.window_closed !== want.window_closed)
                        report_mismatch($sformatf("window_closed %0b, expected %0b",
                            out_data.window_closed, want.window_closed));
                end
            end
            if (in_valid && in_ready)
            begin
                got = predict_depth(in_data);
                tag = preset_q.pop_front();
                pending_depths.insert(pending_depths.size(), tag.typed ? tag.golden : got);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_INITIAL_DEPTH:
                        track.current_depth = cfg_data[DEPTH_W-1:0];
                    CFG_MIN_DEPTH:
                        limits.min_depth = cfg_data[DEPTH_W-1:0];
                    CFG_MAX_DEPTH:
                        limits.max_depth = cfg_data[DEPTH_W-1:0];
                    CFG_TARGET:
                        limits.target_latency_us = cfg_data[TARGET_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // cycles to wait before the next transfer, zero during calm stretches
    function automatic int pick_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = pick_wait();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // stop offering and wait until every expected result has been taken
    task automatic wait_drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge clk); while (pending_depths.size() != 0);
    endtask

    // register writes happen only with the block drained; valid stays up on return
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] val);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // offer one report and wait for its transfer
    task automatic send_report(input in_item_t item, input logic typed, input out_item_t golden);
        int gap;
        cfg_valid <= 1'b0;
        gap = burst ? 0 : pick_wait();
        preset_q.insert(preset_q.size(), preset_t'({typed, golden}));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    function automatic plan_row_t report_row(input logic fsync, input logic [31:0] bytes,
                                             input logic [31:0] lat, input logic typed,
                                             input logic [DEPTH_W-1:0] depth,
                                             input logic closed);
        plan_row_t row;
        row = '0;
        row.kind = ROW_REPORT;
        row.report.is_fsync = fsync;
        row.report.result_bytes = bytes;
        row.report.latency_us = lat;
        row.typed = typed;
        row.golden.depth_limit = depth;
        row.golden.window_closed = closed;
        return row;
    endfunction

    function automatic plan_row_t write_row(input cfg_index_t idx,
                                            input logic [CFG_DAT_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    initial
    begin : stimulus
        plan_row_t            plan[$];
        in_item_t             item;
        logic [CFG_DAT_W-1:0] lo;
        logic [CFG_DAT_W-1:0] hi;
        logic [CFG_DAT_W-1:0] init;
        logic [CFG_DAT_W-1:0] tgt_val;
        logic [LAT_W-1:0]     tgt;
        logic [31:0]          bytes_cap;
        logic [31:0]          step_bytes;
        int                   lat_mode;
        int                   byte_mode;
        int                   counted;

        // tracker starts from the register reset values
        track.current_depth = INITIAL_DEPTH_RST;
        limits.min_depth = MIN_DEPTH_RST;
        limits.max_depth = MAX_DEPTH_RST;
        limits.target_latency_us = TARGET_RST;

        // ignored reports after reset: flush, zero bytes, most negative error
        plan.insert(plan.size(),
            report_row(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 13'd32, 1'b0));
        plan.insert(plan.size(),
            report_row(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 13'd32, 1'b0));
        plan.insert(plan.size(),
            report_row(1'b0, 32'h8000_0000, 32'h0000_0000, 1'b1, 13'd32, 1'b0));
        // low-latency window at full byte count: depth 32 grows to 39
        for (int i = 0; i < 7; i++)
            plan.insert(plan.size(),
                report_row(1'b0, 32'h7FFF_FFFF, 32'd0, 1'b1, 13'd32, 1'b0));
        plan.insert(plan.size(), report_row(1'b0, 32'd1, 32'd999, 1'b1, 13'd39, 1'b1));
        // depth 39 shrinks to 27: every report is as slow as the field allows
        for (int i = 0; i < 7; i++)
            plan.insert(plan.size(),
                report_row(1'b0, 32'd1, 32'hFFFF_FFFF, 1'b1, 13'd39, 1'b0));
        plan.insert(plan.size(),
            report_row(1'b0, 32'd1, 32'hFFFF_FFFF, 1'b1, 13'd27, 1'b1));
        // over-wide initial depth is cut to 13 bits and loads the depth
        plan.insert(plan.size(), write_row(CFG_INITIAL_DEPTH, 31'h7FFF_FFFF));
        plan.insert(plan.size(), report_row(1'b1, 32'd5, 32'd0, 1'b1, 13'd8191, 1'b0));
        // min above max, max of zero, target at its top
        plan.insert(plan.size(), write_row(CFG_MAX_DEPTH, 31'd0));
        plan.insert(plan.size(), write_row(CFG_MIN_DEPTH, 31'd4096));
        plan.insert(plan.size(), write_row(CFG_TARGET, 31'h7FFF_FFFF));
        for (int i = 0; i < 3; i++)
            plan.insert(plan.size(),
                report_row(1'b0, 32'd1 << (i * 10), 32'd7, 1'b0, '0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_report(plan[i].report, plan[i].typed, plan[i].golden);
        end

        // random windows under a new register setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = 31'd1;
                    hi = 31'd4096;
                    tgt_val = 31'd0;
                    init = 31'd4096;
                end
                1:
                begin
                    lo = 31'd4096;
                    hi = 31'd4096;
                    tgt_val = 31'h7FFF_FFFF;
                    init = 31'd1;
                end
                2:
                begin
                    // inconsistent pair, applied as written
                    lo = 31'd200;
                    hi = 31'd50;
                    tgt_val = 31'd5000;
                    init = 31'd100;
                end
                3:
                begin
                    lo = 31'd0;
                    hi = 31'd0;
                    tgt_val = CFG_DAT_W'($urandom_range(1, 1000));
                    init = 31'd8191;
                end
                4:
                begin
                    // wide random values exercise the register masking
                    lo = CFG_DAT_W'($urandom);
                    hi = CFG_DAT_W'($urandom);
                    tgt_val = CFG_DAT_W'($urandom_range(0, 50000));
                    init = CFG_DAT_W'($urandom);
                end
                default:
                begin
                    lo = CFG_DAT_W'($urandom_range(1, 64));
                    hi = CFG_DAT_W'($urandom_range(64, 4096));
                    tgt_val = CFG_DAT_W'($urandom_range(1, 100000));
                    init = CFG_DAT_W'($urandom_range(1, 4096));
                end
            endcase
            write_reg(CFG_MIN_DEPTH, lo);
            write_reg(CFG_MAX_DEPTH, hi);
            write_reg(CFG_TARGET, tgt_val);
            write_reg(CFG_INITIAL_DEPTH, init);
            tgt = LAT_W'(tgt_val);

            // no idling at all on either side for one phase
            calm = (phase == 6);

            for (int w = 0; w < WINDOWS_PER_PHASE; w++)
            begin
                // back-to-back reports against a long receiver hold-off
                if (phase == 5 && w == 0)
                    hold_req = 1'b1;
                burst = (phase == 5 && w < 3);
                // sender pause mid-phase until all results are back
                if (phase == 7 && w == 7)
                    wait_drain();

                lat_mode = $urandom_range(0, 3);
                byte_mode = $urandom_range(0, 5);
                case (byte_mode)
                    0:       bytes_cap = $urandom_range(1, 255);
                    1:       bytes_cap = $urandom_range(1, 1 << 20);
                    2:       bytes_cap = 32'h7FFF_FFFF;
                    default: bytes_cap = 32'd0;
                endcase
                // constant per-report bytes near 49:50 land on the growth threshold
                step_bytes = $urandom_range(48, 50);

                counted = 0;
                while (counted < WINDOW_LEN)
                begin
                    item.is_fsync = 1'b0;
                    item.latency_us = $urandom;
                    if ($urandom_range(0, 5) == 0)
                    begin
                        // noise: flushes, zero results and error codes
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                item.is_fsync = 1'b1;
                                item.result_bytes = $urandom;
                            end
                            1:       item.result_bytes = '0;
                            default: item.result_bytes = $urandom | 32'h8000_0000;
                        endcase
                    end
                    else
                    begin
                        item.result_bytes = (byte_mode >= 3) ? step_bytes
                                                             : $urandom_range(1, bytes_cap);
                        case (lat_mode)
                            0:
                                item.latency_us = (tgt == 0) ? '0 : $urandom_range(0, tgt - 1);
                            1:
                                item.latency_us = ($urandom_range(0, 2) == 0)
                                    ? $urandom_range(2 * tgt + 1, 32'hFFFF_FFFF)
                                    : $urandom_range(0, tgt);
                            2:
                                item.latency_us = $urandom_range(tgt, 2 * tgt);
                            default:
                                item.latency_us = $urandom;
                        endcase
                        counted++;
                    end
                    send_report(item, 1'b0, '0);
                end
            end
            burst = 1'b0;
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_depths.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/aqdc_pkg.sv
sv/aqdc_eval.sv
sv/adaptive_queue_depth_control.sv
bench/tb_adaptive_queue_depth_control.sv
